/* rtl/lru_pkg.sv */
// shared constants and types for the lru page replacement block
// no dependencies; used by lru_cell and lru_page_replacement_top
`default_nettype none

package lru_pkg;

   localparam int MaxWays   = 16;
   localparam int PageBits  = 16;
   localparam int OccBits   = $clog2(MaxWays + 1);
   localparam int IdxBits   = (MaxWays > 1) ? $clog2(MaxWays) : 1;
   localparam int CapBits   = 5;
   localparam int MissBits  = 32;
   localparam int DataBits  = 32;
   localparam int AddrBits  = 3;
   localparam int CapReset  = 4;

   // register index taken from the address
   localparam logic RegCapacity = 1'b0;

   // broadcast from the top level to every cell of the stack
   typedef struct packed {
      logic                fire;
      logic                hit;
      logic [PageBits-1:0] page;
   } lru_cell_ctl_type;

endpackage

`default_nettype wire

/* rtl/lru_page_replacement_top.sv */
// fully associative lru page store: a row of lru_cell entries plus the
// occupancy, miss counter, capacity register and result register; uses lru_pkg
//
// usage:
//   requests arrive on req_valid/req_ready with req_page and req_start_req;
//   each request gives exactly one result on rsp_valid/rsp_ready with rsp_hit,
//   rsp_evicted_valid, rsp_evicted_page and rsp_miss_count.
//   a request is handled in the cycle it is accepted (parallel compare in every
//   cell, then one shift of the stack) and its result sits in the output
//   register from the next cycle; one request per cycle while results are taken.
//   the rate is set by the compare and shift across the cells.
//   when the receiver stalls, the result register holds and req_ready drops
//   until the result is taken; a request is accepted in the same cycle that
//   the waiting result leaves.
//   reset empties the store, clears the miss count and sets capacity to 4;
//   no clearing pass is needed. capacity is written over the csr port at
//   byte address 0 and should change only together with a start request.
`default_nettype none

module lru_page_replacement_top (
   input  wire                               clock,
   input  wire                               reset,
   // request channel
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire  [lru_pkg::PageBits-1:0]      req_page,
   input  wire                               req_start_req,
   // result channel
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic                              rsp_hit,
   output logic                              rsp_evicted_valid,
   output logic [lru_pkg::PageBits-1:0]      rsp_evicted_page,
   output logic [lru_pkg::MissBits-1:0]      rsp_miss_count,
   // configuration port
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [lru_pkg::AddrBits-1:0]      csr_paddr,
   input  wire  [lru_pkg::DataBits-1:0]      csr_pwdata,
   output logic [lru_pkg::DataBits-1:0]      csr_prdata,
   output logic                              csr_pready
);

   localparam int Ways = lru_pkg::MaxWays;
   localparam int OccW = lru_pkg::OccBits;
   localparam int IdxW = lru_pkg::IdxBits;
   localparam int CapW = lru_pkg::CapBits;
   localparam int MisW = lru_pkg::MissBits;
   localparam int PgW  = lru_pkg::PageBits;
   localparam int DatW = lru_pkg::DataBits;

   logic [CapW-1:0] capacity_ff;
   logic [CapW-1:0] capacity_in;
   logic [OccW-1:0] occ_ff;
   logic [OccW-1:0] occ_in;
   logic [MisW-1:0] miss_ff;
   logic [MisW-1:0] miss_in;

   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            hit_ff;
   logic            hit_in;
   logic            ev_valid_ff;
   logic            ev_valid_in;
   logic [PgW-1:0]  ev_page_ff;
   logic [PgW-1:0]  ev_page_in;
   logic [MisW-1:0] miss_count_ff;

   logic            fire;
   logic            csr_write;
   logic [OccW-1:0] cap_eff;
   logic [OccW-1:0] occ_eff;
   logic [OccW-1:0] occ_m1;
   logic [OccW-1:0] miss_top;
   logic [MisW-1:0] miss_base;
   logic            hit;
   logic            evict;

   lru_pkg::lru_cell_ctl_type ctl;

   logic [PgW-1:0]  stack_q [Ways];
   logic [Ways:0]   seen;
   logic [Ways-1:0] live;
   logic [Ways-1:0] shift_miss;

   // handshakes
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign fire       = req_valid && req_ready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   // capacity register
   always_comb begin
      capacity_in = capacity_ff;
      if (csr_write && (csr_paddr[2] == lru_pkg::RegCapacity)) begin
         capacity_in = csr_pwdata[CapW-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == lru_pkg::RegCapacity) begin
         csr_prdata = {{(DatW-CapW){1'b0}}, capacity_ff};
      end
   end

   // clamp capacity to 1..Ways
   always_comb begin
      priority if (capacity_ff == '0) begin
         cap_eff = OccW'(1);
      end else if ({{(32-CapW){1'b0}}, capacity_ff} > 32'(Ways)) begin
         cap_eff = OccW'(Ways);
      end else begin
         cap_eff = OccW'(capacity_ff);
      end
   end

   // a start request sees an empty store and a cleared counter
   assign occ_eff   = req_start_req ? '0 : occ_ff;
   assign miss_base = req_start_req ? '0 : miss_ff;
   assign occ_m1    = occ_eff - OccW'(1);

   assign ctl.fire = fire;
   assign ctl.hit  = hit;
   assign ctl.page = req_page;

   assign seen[0] = 1'b0;
   assign hit     = seen[Ways];
   assign evict   = !hit && (occ_eff >= cap_eff) && (occ_eff != '0);
   assign miss_top = evict ? occ_m1 : occ_eff;

   genvar gi;
   generate
      for (gi = 0; gi < Ways; gi++) begin : g_cell
         logic [PgW-1:0] prev_page;
         assign live[gi]       = OccW'(gi) < occ_eff;
         assign shift_miss[gi] = OccW'(gi) <= miss_top;
         if (gi == 0) begin : g_head
            assign prev_page = req_page;
         end else begin : g_body
            assign prev_page = stack_q[gi-1];
         end
         lru_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .live       (live[gi]),
            .shift_miss (shift_miss[gi]),
            .prev_page  (prev_page),
            .seen_in    (seen[gi]),
            .page_out   (stack_q[gi]),
            .seen_out   (seen[gi+1])
         );
      end
   endgenerate

   // occupancy and miss counter
   always_comb begin
      occ_in  = occ_ff;
      miss_in = miss_ff;
      if (fire) begin
         occ_in  = occ_eff;
         miss_in = miss_base;
         if (!hit) begin
            if (miss_base != {MisW{1'b1}}) begin
               miss_in = miss_base + MisW'(1);
            end
            if (!evict) begin
               occ_in = occ_eff + OccW'(1);
            end
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      hit_in       = hit_ff;
      ev_valid_in  = ev_valid_ff;
      ev_page_in   = ev_page_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
         hit_in       = hit;
         ev_valid_in  = evict;
         ev_page_in   = evict ? stack_q[occ_m1[IdxW-1:0]] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CapW'(lru_pkg::CapReset);
         occ_ff       <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         occ_ff       <= occ_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff      <= hit_in;
      ev_valid_ff <= ev_valid_in;
      ev_page_ff  <= ev_page_in;
      if (fire) begin
         miss_count_ff <= miss_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_evicted_valid = ev_valid_ff;
   assign rsp_evicted_page  = ev_page_ff;
   assign rsp_miss_count    = miss_count_ff;

endmodule

`default_nettype wire

/* rtl/lru_cell.sv */
// one entry of the recency stack: holds a page, compares it with the request
// and takes its upper neighbor's page when the stack shifts; uses lru_pkg
`default_nettype none

module lru_cell (
   input  wire                             clock,
   input  wire lru_pkg::lru_cell_ctl_type  ctl,
   input  wire                             live,
   input  wire                             shift_miss,
   input  wire  [lru_pkg::PageBits-1:0]    prev_page,
   input  wire                             seen_in,
   output logic [lru_pkg::PageBits-1:0]    page_out,
   output logic                            seen_out
);

   logic [lru_pkg::PageBits-1:0] page_ff;
   logic [lru_pkg::PageBits-1:0] page_in;
   logic                         match;
   logic                         shift;

   assign match    = live && (page_ff == ctl.page);
   assign seen_out = seen_in || match;
   assign page_out = page_ff;

   // on a hit only cells up to the first match move; on a miss the top decides
   assign shift = ctl.hit ? !seen_in : shift_miss;

   always_comb begin
      page_in = page_ff;
      if (ctl.fire && shift) begin
         page_in = prev_page;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

endmodule

`default_nettype wire
